/* rtl/arse_pkg.sv */
// shared types and constants of the adaptive random search engine
// no dependencies; imported by arse_draw and adaptive_random_search_engine
`default_nettype none

package arse_pkg;

  localparam int ValueBits    = 32;
  localparam int MaxParamsDef = 16;
  localparam int MaxKeptDef   = 32;
  localparam int CfgIdxBits   = 3;

  // 9999.0 in q16.16, starting minimum of a bound rebuild
  localparam logic signed [ValueBits-1:0] StartMin = 32'sd655294464;

  localparam logic [47:0] LcgMul  = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LcgAdd  = 48'h0000_0000_000B;
  localparam logic [15:0] SeedLow = 16'h330E;

  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdGen   = 2'd1,
    CmdScore = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgParamCount = 3'd0,
    CfgKeepCount  = 3'd1,
    CfgCritical   = 3'd2,
    CfgMaximize   = 3'd3,
    CfgBurnIn     = 3'd4,
    CfgConverge   = 3'd5,
    CfgSeed       = 3'd6,
    CfgSpare      = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StGenRd,
    StGenGo,
    StGenWait,
    StGenEmit,
    StScan,
    StDecide,
    StCpRd,
    StCpWr,
    StAdRd,
    StAdCmp,
    StAdWr,
    StSpread,
    StScEmit
  } state_e;

  // control from the sequencer to the draw unit
  typedef struct packed {
    logic        start;
    logic        reseed;
    logic [31:0] seed;
  } draw_req_t;

endpackage

`default_nettype wire

/* rtl/adaptive_random_search_engine.sv */
// top level of the adaptive random search engine: sequencer, bound,
// candidate and kept-set memories, ranked kept list; uses arse_pkg, arse_draw
`default_nettype none

// channel   direction  fields                                         handshake
// in        sink       command param_index bound_low bound_high score in_valid/in_ready
// out       source     out_index param_value last accepted inserted     out_valid/out_ready
//                      converged best_score spread
// cfg       sink       cfg_index cfg_data                              cfg_valid/cfg_ready
//
// load writes its bounds straight from idle. generate runs, per parameter, a bound read,
// operand capture, lcg step, scaling multiply, result and emit. score runs a
// ranking scan over up to kept_used+1 ranks, a read-and-write row copy of all
// MAX_PARAMS words, and when adapting a read and compare over kept_used rows
// and a bound write for each of param_count parameters. one item is in work at a time.
// reset needs no clearing pass; memories hold garbage until written.
// a full output register stalls the sequencer; config is always ready.

module adaptive_random_search_engine #(
  parameter int MaxParams = arse_pkg::MaxParamsDef,
  parameter int MaxKept   = arse_pkg::MaxKeptDef
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [1:0]                            command_i,
  input  wire logic [3:0]                            param_index_i,
  input  wire logic signed [arse_pkg::ValueBits-1:0] bound_low_i,
  input  wire logic signed [arse_pkg::ValueBits-1:0] bound_high_i,
  input  wire logic signed [arse_pkg::ValueBits-1:0] score_i,
  output logic                                       out_valid_o,
  input  wire                                        out_ready_i,
  output logic [3:0]                                 out_index_o,
  output logic signed [arse_pkg::ValueBits-1:0]      param_value_o,
  output logic                                       last_o,
  output logic                                       accepted_o,
  output logic                                       inserted_o,
  output logic                                       converged_o,
  output logic signed [arse_pkg::ValueBits-1:0]      best_score_o,
  output logic signed [arse_pkg::ValueBits-1:0]      spread_o,
  input  wire                                        cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [arse_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  wire logic [31:0]                           cfg_data_i
);
  import arse_pkg::*;

  // address and counter widths
  localparam int PAW = (MaxParams > 1) ? $clog2(MaxParams) : 1;
  localparam int KAW = (MaxKept > 1) ? $clog2(MaxKept) : 1;
  localparam int PCW = $clog2(MaxParams + 1);
  localparam int KCW = $clog2(MaxKept + 1);
  localparam int KPW = (MaxKept * MaxParams > 1) ? $clog2(MaxKept * MaxParams) : 1;

  // configuration registers
  logic [4:0]         param_count_q;
  logic [5:0]         keep_count_q;
  logic signed [31:0] critical_q;
  logic               maximize_q;
  logic [15:0]        burn_in_q;
  logic [30:0]        converge_q;

  // sequencer and search state
  state_e             state_q, state_d;
  logic [PCW-1:0]     idx_q;          // parameter counter
  logic [KCW-1:0]     rank_q;         // kept-list counter
  logic [KCW-1:0]     pos_q;          // insertion rank
  logic [KCW-1:0]     kept_used_q;
  logic [KAW-1:0]     slot_q;         // physical row of new set
  logic [31:0]        good_total_q;
  logic signed [31:0] last_spread_q;
  logic signed [31:0] sc_q;
  logic               acc_q, ins_q;
  logic signed [31:0] mn_q, mx_q;
  logic signed [31:0] val_q;

  // ranked list: score by rank and row pointer by rank, always a permutation
  logic signed [31:0] score_q [MaxKept];
  logic [KAW-1:0]     order_q [MaxKept];

  // memories
  logic signed [31:0] lo_mem   [MaxParams];
  logic signed [31:0] hi_mem   [MaxParams];
  logic signed [31:0] cand_mem [MaxParams];
  logic signed [31:0] kept_mem [MaxKept * MaxParams];
  logic signed [31:0] lo_rd_q, hi_rd_q, cand_rd_q, kept_rd_q;

  // output register
  logic               out_valid_q;
  logic [3:0]         out_index_q;
  logic signed [31:0] param_value_q, best_q, spread_q;
  logic               last_q, accepted_q, inserted_q, converged_q;

  // draw unit
  draw_req_t          draw_req;
  logic               draw_done;
  logic signed [31:0] draw_value;

  // effective counts
  logic [PCW-1:0] np;
  logic [KCW-1:0] kc;
  logic [KCW-1:0] used_cut, nn;
  logic [KAW-1:0] new_slot;

  logic       in_acc, out_free, out_load, cfg_wr;
  logic       is_better, acc_now, no_room, converged_now;
  logic signed [31:0] scan_score, kept_v;
  logic signed [32:0] spread_full;
  logic signed [31:0] spread_sat;

  logic           bnd_we, cand_we, kept_we;
  logic [PAW-1:0] bnd_wa, bnd_ra, cand_a;
  logic signed [31:0] bnd_wlo, bnd_whi;
  logic [KPW-1:0] kept_wa, kept_ra;

  always_comb begin
    if (param_count_q == 5'd0) begin
      np = PCW'(1);
    end else if (32'(param_count_q) > MaxParams) begin
      np = PCW'(MaxParams);
    end else begin
      np = PCW'(param_count_q);
    end
    if (keep_count_q == 6'd0) begin
      kc = KCW'(1);
    end else if (32'(keep_count_q) > MaxKept) begin
      kc = KCW'(MaxKept);
    end else begin
      kc = KCW'(keep_count_q);
    end
  end

  assign used_cut   = (kept_used_q > kc) ? kc : kept_used_q;
  assign nn         = (kept_used_q < kc) ? kept_used_q + KCW'(1) : kc;
  assign new_slot   = order_q[KAW'(nn - KCW'(1))];
  assign scan_score = score_q[rank_q[KAW-1:0]];
  assign is_better  = maximize_q ? (sc_q > scan_score) : (sc_q < scan_score);
  assign acc_now    = maximize_q ? !(score_i < critical_q) : !(score_i > critical_q);
  assign no_room    = (pos_q == kept_used_q) && (kept_used_q >= kc);
  assign kept_v     = kept_rd_q;

  // spread of best and worst kept, saturated to 32 bits
  assign spread_full = 33'(score_q[0]) - 33'(score_q[KAW'(kept_used_q - KCW'(1))]);
  assign spread_sat  = (spread_full[32] != spread_full[31]) ?
                       (spread_full[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) :
                       spread_full[31:0];

  assign converged_now = (good_total_q >= 32'(burn_in_q)) &&
                         (last_spread_q <= $signed({1'b0, converge_q}));

  assign out_free = !out_valid_q || out_ready_i;
  assign in_acc   = in_valid_i && in_ready_o;
  assign cfg_wr   = cfg_valid_i && cfg_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          case (cmd_e'(command_i))
            CmdGen:   state_d = StGenRd;
            CmdScore: state_d = acc_now ? StScan : StScEmit;
            default:  state_d = StIdle;
          endcase
        end
      end
      StGenRd:   state_d = StGenGo;
      StGenGo:   state_d = StGenWait;
      StGenWait: if (draw_done) state_d = StGenEmit;
      StGenEmit: begin
        if (out_free) begin
          state_d = (idx_q + PCW'(1) == np) ? StIdle : StGenRd;
        end
      end
      StScan: begin
        if (rank_q == kept_used_q || is_better) begin
          state_d = StDecide;
        end
      end
      StDecide:  state_d = no_room ? StScEmit : StCpRd;
      StCpRd:    state_d = StCpWr;
      StCpWr: begin
        if (32'(idx_q) == MaxParams - 1) begin
          state_d = (good_total_q > 32'(burn_in_q)) ? StAdRd : StSpread;
        end else begin
          state_d = StCpRd;
        end
      end
      StAdRd:    state_d = StAdCmp;
      StAdCmp:   state_d = (rank_q + KCW'(1) == kept_used_q) ? StAdWr : StAdRd;
      StAdWr:    state_d = (idx_q + PCW'(1) == np) ? StSpread : StAdRd;
      StSpread:  state_d = StScEmit;
      StScEmit:  if (out_free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // control strobes and memory addresses
  always_comb begin
    in_ready_o     = (state_q == StIdle);
    out_load       = ((state_q == StGenEmit) || (state_q == StScEmit)) && out_free;
    draw_req.start  = (state_q == StGenGo);
    draw_req.reseed = cfg_wr && (cfg_idx_e'(cfg_index_i) == CfgSeed);
    draw_req.seed   = cfg_data_i;

    bnd_we  = 1'b0;
    bnd_wa  = idx_q[PAW-1:0];
    bnd_wlo = mn_q;
    bnd_whi = mx_q;
    if (state_q == StIdle && in_acc && cmd_e'(command_i) == CmdLoad) begin
      bnd_we  = 1'b1;
      bnd_wa  = PAW'(32'(param_index_i) % MaxParams);
      bnd_wlo = bound_low_i;
      bnd_whi = bound_high_i;
    end else if (state_q == StAdWr) begin
      bnd_we = 1'b1;
    end
    bnd_ra  = idx_q[PAW-1:0];
    cand_we = (state_q == StGenWait) && draw_done;
    cand_a  = idx_q[PAW-1:0];
    kept_we = (state_q == StCpWr);
    kept_wa = KPW'(slot_q) * KPW'(MaxParams) + KPW'(idx_q);
    kept_ra = KPW'(order_q[rank_q[KAW-1:0]]) * KPW'(MaxParams) + KPW'(idx_q);
  end

  // memories; one item at a time, so a read never meets a write in flight
  always_ff @(posedge clk_i) begin
    if (bnd_we) begin
      lo_mem[bnd_wa] <= bnd_wlo;
      hi_mem[bnd_wa] <= bnd_whi;
    end
    lo_rd_q <= lo_mem[bnd_ra];
    hi_rd_q <= hi_mem[bnd_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cand_we) begin
      cand_mem[cand_a] <= draw_value;
    end
    cand_rd_q <= cand_mem[cand_a];
  end

  always_ff @(posedge clk_i) begin
    if (kept_we) begin
      kept_mem[kept_wa] <= cand_rd_q;
    end
    kept_rd_q <= kept_mem[kept_ra];
  end

  arse_draw u_draw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (draw_req),
    .lo_i    (lo_rd_q),
    .hi_i    (hi_rd_q),
    .done_o  (draw_done),
    .value_o (draw_value)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      param_count_q <= 5'd1;
      keep_count_q  <= 6'd10;
      critical_q    <= '0;
      maximize_q    <= 1'b1;
      burn_in_q     <= '0;
      converge_q    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgParamCount: param_count_q <= cfg_data_i[4:0];
        CfgKeepCount:  keep_count_q  <= cfg_data_i[5:0];
        CfgCritical:   critical_q    <= $signed(cfg_data_i);
        CfgMaximize:   maximize_q    <= cfg_data_i[0];
        CfgBurnIn:     burn_in_q     <= cfg_data_i[15:0];
        CfgConverge:   converge_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // sequencer registers and ranked list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      idx_q         <= '0;
      rank_q        <= '0;
      pos_q         <= '0;
      kept_used_q   <= '0;
      slot_q        <= '0;
      good_total_q  <= '0;
      last_spread_q <= '0;
      acc_q         <= 1'b0;
      ins_q         <= 1'b0;
      for (int k = 0; k < MaxKept; k++) begin
        order_q[k] <= KAW'(k);
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          idx_q  <= '0;
          rank_q <= '0;
          if (in_acc && cmd_e'(command_i) == CmdScore) begin
            kept_used_q <= used_cut;
            acc_q       <= acc_now;
            ins_q       <= 1'b0;
            if (acc_now && good_total_q != 32'hFFFF_FFFF) begin
              good_total_q <= good_total_q + 32'd1;
            end
          end
        end
        StGenEmit: if (out_free) idx_q <= idx_q + PCW'(1);
        StScan: begin
          if (rank_q == kept_used_q || is_better) begin
            pos_q <= rank_q;
          end else begin
            rank_q <= rank_q + KCW'(1);
          end
        end
        StDecide: begin
          if (!no_room) begin
            // worst row drops out (or a free row is taken) and the rest shift
            for (int k = 0; k < MaxKept; k++) begin
              if (KCW'(k) > pos_q && KCW'(k) < nn) begin
                order_q[k] <= order_q[(k > 0) ? k - 1 : 0];
              end else if (KCW'(k) == pos_q) begin
                order_q[k] <= new_slot;
              end
            end
            slot_q      <= new_slot;
            kept_used_q <= nn;
            ins_q       <= 1'b1;
            idx_q       <= '0;
          end
        end
        StCpWr: begin
          idx_q  <= (32'(idx_q) == MaxParams - 1) ? '0 : idx_q + PCW'(1);
          rank_q <= '0;
        end
        StAdCmp:  rank_q <= rank_q + KCW'(1);
        StAdWr: begin
          idx_q  <= idx_q + PCW'(1);
          rank_q <= '0;
        end
        StSpread: last_spread_q <= spread_sat;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_acc) begin
      sc_q <= score_i;
    end
    if (state_q == StDecide && !no_room) begin
      for (int k = 0; k < MaxKept; k++) begin
        if (KCW'(k) > pos_q && KCW'(k) < nn) begin
          score_q[k] <= score_q[(k > 0) ? k - 1 : 0];
        end else if (KCW'(k) == pos_q) begin
          score_q[k] <= sc_q;
        end
      end
    end
    if (state_q == StGenWait && draw_done) begin
      val_q <= draw_value;
    end
    // min/max restart for each parameter of a rebuild
    if (state_q == StCpWr || state_q == StAdWr) begin
      mn_q <= StartMin;
      mx_q <= '0;
    end else if (state_q == StAdCmp) begin
      if (kept_v < mn_q) mn_q <= kept_v;
      if (kept_v > mx_q) mx_q <= kept_v;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == StGenEmit) begin
        out_index_q   <= 4'(idx_q);
        param_value_q <= val_q;
        last_q        <= (idx_q + PCW'(1) == np);
        accepted_q    <= 1'b0;
        inserted_q    <= 1'b0;
        converged_q   <= 1'b0;
        best_q        <= '0;
        spread_q      <= '0;
      end else begin
        out_index_q   <= '0;
        param_value_q <= '0;
        last_q        <= 1'b1;
        accepted_q    <= acc_q;
        inserted_q    <= ins_q;
        converged_q   <= converged_now;
        best_q        <= (kept_used_q != '0) ? score_q[0] : '0;
        spread_q      <= last_spread_q;
      end
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_index_q;
  assign param_value_o = param_value_q;
  assign last_o        = last_q;
  assign accepted_o    = accepted_q;
  assign inserted_o    = inserted_q;
  assign converged_o   = converged_q;
  assign best_score_o  = best_q;
  assign spread_o      = spread_q;

  // kept list never grows past its storage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(kept_used_q) <= MaxKept)
    else $error("kept list overflow");

  // a draw completes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_done |-> state_q == StGenWait)
    else $error("unexpected draw completion");

  // insertion rank never lies beyond the list end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDecide |-> pos_q <= kept_used_q)
    else $error("insertion rank out of range");

  // an inserted result leaves a nonempty list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && state_q == StScEmit && ins_q) |-> kept_used_q != '0)
    else $error("insertion with empty list");

endmodule

`default_nettype wire

/* rtl/arse_draw.sv */
// random draw unit: 48-bit lcg step and uniform scaling between two bounds
// depends on arse_pkg
`default_nettype none

module arse_draw (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  arse_pkg::draw_req_t                   req_i,
  input  wire logic signed [arse_pkg::ValueBits-1:0] lo_i,
  input  wire logic signed [arse_pkg::ValueBits-1:0] hi_i,
  output logic                                  done_o,
  output logic signed [arse_pkg::ValueBits-1:0] value_o
);
  import arse_pkg::*;

  logic [47:0] rng_q;
  logic        v1_q, v2_q, v3_q;
  logic [47:0] pp0_q;
  logic [15:0] pp1_q, pp2_q;
  logic signed [31:0] lo_q;
  logic [31:0] mag_q;
  logic        neg_q;
  logic [62:0] prod_q;

  logic signed [32:0] diff;
  logic [63:0] p0;
  logic [31:0] p1, p2;
  logic [47:0] rng_d;

  always_comb begin
    diff  = 33'(hi_i) - 33'(lo_i);
    p0    = rng_q[31:0] * LcgMul[31:0];
    p1    = 32'(rng_q[47:32]) * 32'(LcgMul[15:0]);
    p2    = 32'(rng_q[15:0]) * 32'(LcgMul[34:32]);
    rng_d = pp0_q + {16'(pp1_q + pp2_q), 32'd0} + LcgAdd;
  end

  // rng state: split product, high partial products only matter mod 2^48
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q <= {32'd0, SeedLow};
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (req_i.reseed) begin
        rng_q <= {req_i.seed, SeedLow};
      end else if (v1_q) begin
        rng_q <= rng_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      pp0_q <= p0[47:0];
      pp1_q <= p1[15:0];
      pp2_q <= p2[15:0];
      lo_q  <= lo_i;
      neg_q <= diff[32];
      mag_q <= diff[32] ? 32'(-diff) : diff[31:0];
    end
    if (v2_q) begin
      prod_q <= 63'(mag_q * 63'(rng_q[47:17]));
    end
  end

  assign done_o  = v3_q;
  assign value_o = neg_q ? lo_q - $signed(prod_q[62:31]) : lo_q + $signed(prod_q[62:31]);

endmodule

`default_nettype wire
